// ===== rtl/stereo_feedback_delay_line_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stereo feedback delay line
// Clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_DELAY_LINE_TOP_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_LINE_TOP_ASSERT_SVH

// cond must hold at every edge out of reset
`define SFDL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication
`define SFDL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfdl_pkg.sv =====
// ----------------------------------------------------------------------------
// sfdl_pkg
// Shared types and constants of the stereo feedback delay line.
// ----------------------------------------------------------------------------
package sfdl_pkg;

    localparam int IO_W      = 16;     // sample width on the stream ports
    localparam int GAIN_W    = 15;     // unsigned Q0.15 gain
    localparam int DELAY_W   = 16;     // delay register width
    localparam int DELAY_MAX = 65535;  // largest programmable delay
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 5;

    localparam int DELAY_RST = 24000;
    localparam int GAIN_RST  = 16384;

    typedef enum logic [2:0] {
        REG_ENABLE        = 3'd0,
        REG_LEFT_DELAY    = 3'd1,
        REG_RIGHT_DELAY   = 3'd2,
        REG_FEEDBACK_GAIN = 3'd3,
        REG_SIDE_SYNC     = 3'd4,
        REG_PING_PONG     = 3'd5
    } cfg_index_t;

    // run mode; its enable bit is sampled when a beat is taken
    typedef struct packed {
        logic              enable;
        logic [GAIN_W-1:0] gain;
    } run_cfg_t;

    // per-channel pipeline strobes
    typedef struct packed {
        logic load;   // run-mode beat enters stage 1, memory read issued
        logic wb_en;  // stage 1 beat retires, memory write issued
    } chan_ctl_t;

endpackage

// ===== rtl/stereo_feedback_delay_line_top.sv =====
// ----------------------------------------------------------------------------
// stereo_feedback_delay_line_top
// Stereo feedback delay with side-sync and ping-pong modes, one frame a beat.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  s_        in         s_tvalid / s_tready       s_tdata: left_in, right_in
//  m_        out        m_tvalid / m_tready       m_tdata: left_out, right_out
//  apb       in         psel/penable/pwrite       paddr, pwdata -> prdata
//
//  Throughput: one stereo frame per cycle while m_tready is high. Each
//    channel memory sees at most one read (at a run-mode accept) and one
//    write (at retire) per cycle. A taken beat is registered in stage 1,
//    then in the output register, which holds it while m_tready is low.
//  Reset: synchronous, active low. No clearing pass: the write pointer only
//    moves forward, so slots at or past it read as zero until it first wraps.
//  Stalls: up to two frames are held (stage 1 and the output register);
//    s_tready stays high while the output register is empty or drains.
//
module stereo_feedback_delay_line_top
    import sfdl_pkg::*;
#(
    parameter int DEPTH       = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*IO_W-1:0]   s_tdata,   // [15:0] left_in, [31:16] right_in
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*IO_W-1:0]   m_tdata,   // [15:0] left_out, [31:16] right_out
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] WP_LAST = AW'(DEPTH - 1);

    run_cfg_t               run_cfg;
    logic [AW-1:0]          left_dly;
    logic [AW-1:0]          right_dly;

    logic                   accept;
    logic                   advance;
    chan_ctl_t              ctl;
    logic [AW-1:0]          wp_next;
    logic signed [IO_W-1:0] left_dout;
    logic signed [IO_W-1:0] right_dout;

    logic [AW-1:0]          wp_reg;
    logic                   full_reg;      // write pointer has wrapped once
    logic                   s1_valid_reg;
    logic                   s1_run_reg;    // beat taken with the delay enabled
    logic [AW-1:0]          s1_wp_reg;
    logic [2*IO_W-1:0]      s1_bypass_reg; // raw frame for pass-through
    logic                   m_valid_reg;
    logic [2*IO_W-1:0]      m_data_reg;

    sfdl_cfg_regs #(
        .DEPTH (DEPTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .run_cfg   (run_cfg),
        .left_dly  (left_dly),
        .right_dly (right_dly)
    );

    // Output register frees up when empty or taken; stage 1 moves only then.
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Disabled beats bypass the memories and leave the pointer alone.
    assign ctl.load  = accept && run_cfg.enable;
    assign ctl.wb_en = s1_valid_reg && s1_run_reg && advance;

    assign wp_next = (wp_reg == WP_LAST) ? '0 : wp_reg + AW'(1);

    sfdl_channel #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_left (
        .aclk  (aclk),
        .ctl   (ctl),
        .gain  (run_cfg.gain),
        .wp    (wp_reg),
        .s1_wp (s1_wp_reg),
        .full  (full_reg),
        .dly   (left_dly),
        .din   (s_tdata[IO_W-1:0]),
        .dout  (left_dout)
    );

    sfdl_channel #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_right (
        .aclk  (aclk),
        .ctl   (ctl),
        .gain  (run_cfg.gain),
        .wp    (wp_reg),
        .s1_wp (s1_wp_reg),
        .full  (full_reg),
        .dly   (right_dly),
        .din   (s_tdata[2*IO_W-1:IO_W]),
        .dout  (right_dout)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (ctl.load) begin
                wp_reg <= wp_next;
                if (wp_reg == WP_LAST) begin
                    full_reg <= 1'b1;
                end
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_run_reg    <= run_cfg.enable;
            s1_wp_reg     <= wp_reg;
            s1_bypass_reg <= s_tdata;
        end
        if (advance && s1_valid_reg) begin
            m_data_reg <= s1_run_reg ? {right_dout, left_dout} : s1_bypass_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/sfdl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sfdl_cfg_regs
// APB register file; keeps delays reduced modulo the memory depth.
// ----------------------------------------------------------------------------
module sfdl_cfg_regs
    import sfdl_pkg::*;
#(
    parameter int DEPTH = 65536
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_AW-1:0]         paddr,
    input  logic [CFG_DW-1:0]         pwdata,
    output logic [CFG_DW-1:0]         prdata,
    output logic                      pready,
    output run_cfg_t                  run_cfg,
    output logic [$clog2(DEPTH)-1:0]  left_dly,
    output logic [$clog2(DEPTH)-1:0]  right_dly
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [DELAY_W-1:0] DLY_RST_MOD  = DELAY_W'(DELAY_RST % DEPTH);
    localparam logic [DELAY_W-1:0] HALF_RST_MOD = DELAY_W'(((DELAY_RST + 1) / 2) % DEPTH);

    logic                wr;
    logic [DELAY_W-1:0]  wdat;
    logic [DELAY_W:0]    half_sum;
    logic [DELAY_W-1:0]  wdat_half;
    logic [DELAY_W-1:0]  res_raw;
    logic [DELAY_W-1:0]  res_half;
    cfg_index_t          idx;

    logic                enable_reg;
    logic [DELAY_W-1:0]  left_delay_reg;
    logic [DELAY_W-1:0]  right_delay_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic                side_sync_reg;
    logic                ping_pong_reg;
    logic [DELAY_W-1:0]  left_mod_reg;
    logic [DELAY_W-1:0]  right_mod_reg;
    logic [DELAY_W-1:0]  half_mod_reg;
    logic [DELAY_W-1:0]  dl_eff;
    logic [DELAY_W-1:0]  dr_eff;

    assign pready    = 1'b1;
    assign wr        = psel && penable && pwrite && pready;
    assign idx       = cfg_index_t'(paddr[CFG_AW-1:2]);
    assign wdat      = pwdata[DELAY_W-1:0];
    assign half_sum  = {1'b0, wdat} + (DELAY_W+1)'(1);
    assign wdat_half = half_sum[DELAY_W:1];

    // Residue of the written delay (and of its rounded-up half).
    if (DEPTH > DELAY_MAX) begin : g_direct
        assign res_raw  = wdat;
        assign res_half = wdat_half;
    end else begin : g_recip
        // quotient by reciprocal multiply, taken in the APB setup cycle;
        // remainder formed in the access cycle
        localparam int     SH    = DELAY_W + $clog2(DEPTH);
        localparam longint RECIP = ((longint'(1) << SH) + longint'(DEPTH) - 1) / longint'(DEPTH);
        localparam int     MW    = DELAY_W + 2;
        localparam int     PW    = DELAY_W + MW;
        localparam logic [DELAY_W-1:0] DEPTH_D = DELAY_W'(DEPTH);

        logic               setup;
        logic [PW-1:0]      p_raw;
        logic [PW-1:0]      p_half;
        logic [DELAY_W-1:0] q_raw_reg;
        logic [DELAY_W-1:0] q_half_reg;

        assign setup  = psel && !penable;
        assign p_raw  = PW'(wdat) * PW'(RECIP);
        assign p_half = PW'(wdat_half) * PW'(RECIP);

        always_ff @(posedge aclk) begin
            if (setup) begin
                q_raw_reg  <= DELAY_W'(p_raw >> SH);
                q_half_reg <= DELAY_W'(p_half >> SH);
            end
        end

        assign res_raw  = wdat - DELAY_W'(q_raw_reg * DEPTH_D);
        assign res_half = wdat_half - DELAY_W'(q_half_reg * DEPTH_D);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            left_delay_reg  <= DELAY_W'(DELAY_RST);
            right_delay_reg <= DELAY_W'(DELAY_RST);
            gain_reg        <= GAIN_W'(GAIN_RST);
            side_sync_reg   <= 1'b0;
            ping_pong_reg   <= 1'b0;
            left_mod_reg    <= DLY_RST_MOD;
            right_mod_reg   <= DLY_RST_MOD;
            half_mod_reg    <= HALF_RST_MOD;
        end else if (wr) begin
            unique case (idx)
                REG_ENABLE:        enable_reg <= pwdata[0];
                REG_LEFT_DELAY: begin
                    left_delay_reg <= wdat;
                    left_mod_reg   <= res_raw;
                end
                REG_RIGHT_DELAY: begin
                    right_delay_reg <= wdat;
                    right_mod_reg   <= res_raw;
                    half_mod_reg    <= res_half;
                end
                REG_FEEDBACK_GAIN: gain_reg      <= pwdata[GAIN_W-1:0];
                REG_SIDE_SYNC:     side_sync_reg <= pwdata[0];
                REG_PING_PONG:     ping_pong_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ENABLE:        prdata = CFG_DW'(enable_reg);
            REG_LEFT_DELAY:    prdata = CFG_DW'(left_delay_reg);
            REG_RIGHT_DELAY:   prdata = CFG_DW'(right_delay_reg);
            REG_FEEDBACK_GAIN: prdata = CFG_DW'(gain_reg);
            REG_SIDE_SYNC:     prdata = CFG_DW'(side_sync_reg);
            REG_PING_PONG:     prdata = CFG_DW'(ping_pong_reg);
            default:           prdata = '0;
        endcase
    end

    // ping-pong: left = half of right, right follows left
    assign dl_eff = ping_pong_reg ? half_mod_reg : left_mod_reg;
    assign dr_eff = (side_sync_reg || ping_pong_reg) ? dl_eff : right_mod_reg;

    assign left_dly       = AW'(dl_eff);
    assign right_dly      = AW'(dr_eff);
    assign run_cfg.enable = enable_reg;
    assign run_cfg.gain   = gain_reg;

endmodule

// ===== rtl/sfdl_channel.sv =====
// ----------------------------------------------------------------------------
// sfdl_channel
// One channel: delay memory, read stage and read-modify-write back stage.
// ----------------------------------------------------------------------------
module sfdl_channel
    import sfdl_pkg::*;
#(
    parameter int DEPTH       = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      aclk,
    input  chan_ctl_t                 ctl,
    input  logic [GAIN_W-1:0]         gain,
    input  logic [$clog2(DEPTH)-1:0]  wp,        // slot of the beat being taken
    input  logic [$clog2(DEPTH)-1:0]  s1_wp,     // slot of the beat in stage 1
    input  logic                      full,      // every slot written at least once
    input  logic [$clog2(DEPTH)-1:0]  dly,       // effective delay, already < DEPTH
    input  logic signed [IO_W-1:0]    din,
    output logic signed [IO_W-1:0]    dout
);

    localparam int AW = $clog2(DEPTH);
    localparam int XW = (SAMPLE_BITS > IO_W) ? SAMPLE_BITS : IO_W;
    localparam int SW = XW + 2;
    localparam int PW = XW + GAIN_W + 1;

    localparam longint SB_MAX_L = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint IO_MAX_L = (longint'(1) << (IO_W - 1)) - 1;
    localparam logic signed [SW-1:0] SB_MAX = SW'(SB_MAX_L);
    localparam logic signed [SW-1:0] SB_MIN = SW'(-SB_MAX_L - 1);
    localparam logic signed [SW-1:0] IO_MAX = SW'(IO_MAX_L);
    localparam logic signed [SW-1:0] IO_MIN = SW'(-IO_MAX_L - 1);
    localparam logic signed [PW-1:0] ROUND  = PW'(longint'(1) << (GAIN_W - 1));
    localparam logic [AW:0]          DEPTH_W = (AW + 1)'(DEPTH);

    // floor((x*g + half) / 2^15)
    function automatic logic signed [XW:0] gain_mul(input logic signed [XW-1:0] x,
                                                     input logic [GAIN_W-1:0] g);
        logic signed [PW-1:0] p;
        p = $signed(PW'(x)) * $signed(PW'({1'b0, g})) + ROUND;
        return p[PW-1:GAIN_W];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_store(input logic signed [SW-1:0] v);
        if (v > SB_MAX) begin
            return SB_MAX[SAMPLE_BITS-1:0];
        end else if (v < SB_MIN) begin
            return SB_MIN[SAMPLE_BITS-1:0];
        end else begin
            return v[SAMPLE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [IO_W-1:0] sat_io(input logic signed [SW-1:0] v);
        if (v > IO_MAX) begin
            return IO_MAX[IO_W-1:0];
        end else if (v < IO_MIN) begin
            return IO_MIN[IO_W-1:0];
        end else begin
            return v[IO_W-1:0];
        end
    endfunction

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

    logic [AW:0]                   rd_sum;
    logic [AW-1:0]                 rd_addr;
    logic signed [SAMPLE_BITS-1:0] wi_in;

    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic signed [SAMPLE_BITS-1:0] wi_reg;
    logic signed [SAMPLE_BITS-1:0] fwd_data_reg;
    logic                          dzero_reg;
    logic                          fwd_reg;
    logic                          stale_reg;

    logic signed [SAMPLE_BITS-1:0] tap;
    logic signed [XW:0]            fb;
    logic signed [SW-1:0]          sum;
    logic signed [SAMPLE_BITS-1:0] wb_data;

    // ---- stage 0: read address and input scaling ----
    always_comb begin
        if (wp >= dly) begin
            rd_sum = {1'b0, wp} - {1'b0, dly};
        end else begin
            rd_sum = {1'b0, wp} + DEPTH_W - {1'b0, dly};
        end
        rd_addr = rd_sum[AW-1:0];
    end

    assign wi_in = sat_store(SW'(gain_mul(XW'(din), gain)));

    always_ff @(posedge aclk) begin
        if (ctl.wb_en) begin
            mem[s1_wp] <= wb_data;
        end
        if (ctl.load) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            wi_reg       <= wi_in;
            dzero_reg    <= (dly == '0);
            // stage 1 writes rd_addr at this same edge: keep its value
            fwd_reg      <= ctl.wb_en && (rd_addr == s1_wp);
            fwd_data_reg <= wb_data;
            // slot never written since reset reads as zero
            stale_reg    <= !full && (rd_addr >= wp);
        end
    end

    // ---- stage 1: tap select, feedback add, write back ----
    always_comb begin
        priority if (dzero_reg) begin
            tap = wi_reg;
        end else if (fwd_reg) begin
            tap = fwd_data_reg;
        end else if (stale_reg) begin
            tap = '0;
        end else begin
            tap = rdata_reg;
        end
    end

    assign fb      = gain_mul(XW'(tap), gain);
    assign sum     = SW'(wi_reg) + SW'(fb);
    assign wb_data = sat_store(sum);
    assign dout    = sat_io(SW'(tap));

endmodule

// ===== rtl/sfdl_checker.sv =====
// ----------------------------------------------------------------------------
// sfdl_checker
// Port-level checks on beat flow of the delay line, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_feedback_delay_line_top_assert.svh"

module sfdl_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] held_reg;   // beats taken but not yet delivered

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_reg + 2'(in_beat) - 2'(out_beat);
        end
    end

    `SFDL_ASSERT_ALWAYS(a_held_max, held_reg != 2'd3, "more than two frames in flight")
    `SFDL_ASSERT_IMPL(a_out_has_src, m_tvalid, held_reg != 2'd0, "result beat without input beat")
    `SFDL_ASSERT_IMPL(a_full_stalls, (held_reg == 2'd2) && !out_beat, !s_tready, "input taken while pipe full")
    `SFDL_ASSERT_IMPL(a_empty_takes, !m_tvalid, s_tready, "input stalled with output register empty")
    `SFDL_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

endmodule

bind stereo_feedback_delay_line_top sfdl_checker u_sfdl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo feedback delay line. Frames go in on the
// s_ stream and every accepted one is run through a bit-exact echo model
// kept here (two circular sample stores and a shared write pointer). The
// m_ stream is checked beat by beat against those predictions. Both streams
// idle and stall at random, and the APB registers are set and read back
// between traffic phases.
// ----------------------------------------------------------------------------
module tb_top;
    import sfdl_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 4;       // idle margin after the last result
    localparam int MEM_DEPTH     = 65536;
    localparam int UNUSED_REG    = 6;       // first index past the register map
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_FRAMES  = 100;

    // receiver behaviour
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_e;

    // ------------------------------------------------------------------------
    // DUT ports; the inputs are driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*IO_W-1:0]   s_tdata  = '0;   // [15:0] left_in, [31:16] right_in
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [2*IO_W-1:0]   m_tdata;         // [15:0] left_out, [31:16] right_out
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [CFG_AW-1:0]   paddr    = '0;
    logic [CFG_DW-1:0]   pwdata   = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    stereo_feedback_delay_line_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Echo model: its own copy of the stores, pointer and register file
    // ------------------------------------------------------------------------
    logic signed [IO_W-1:0] echo_mem [0:1][0:MEM_DEPTH-1];
    logic [15:0]            wr_ptr;

    logic                   en_r;
    logic [DELAY_W-1:0]     ldly_r;
    logic [DELAY_W-1:0]     rdly_r;
    logic [GAIN_W-1:0]      gain_r;
    logic                   sync_r;
    logic                   pp_r;

    logic [2*IO_W-1:0]      pending_frames [$];   // predicted output beats
    int                     errors = 0;

    // sender / receiver pacing
    bit                     tx_gaps   = 1'b0;
    int                     burst_left = 1;
    rx_mode_e               rx_mode   = RX_ALWAYS;
    bit                     hold_req  = 1'b0;
    int                     hold_left = 0;
    int unsigned            rx_tick   = 0;
    int unsigned            cycles    = 0;

    // x * g in Q0.15, rounded half up (floor of the biased quotient)
    function automatic longint gain_round(longint x, logic [GAIN_W-1:0] g);
        longint gl;
        gl = g;
        return (x * gl + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [IO_W-1:0] sat16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // One channel: write scaled input, read the tap, fold scaled tap back in.
    // A zero delay reads the slot just written.
    function automatic logic signed [IO_W-1:0] tap_channel(int ch,
            logic signed [IO_W-1:0] x, logic [DELAY_W-1:0] dly);
        logic [15:0]            rd;
        logic signed [IO_W-1:0] tap;
        longint                 xl;
        longint                 tl;
        longint                 cur;
        xl = x;
        rd = wr_ptr - dly;
        echo_mem[ch][wr_ptr] = sat16(gain_round(xl, gain_r));
        tap = echo_mem[ch][rd];
        tl  = tap;
        cur = echo_mem[ch][wr_ptr];
        echo_mem[ch][wr_ptr] = sat16(cur + gain_round(tl, gain_r));
        return tap;
    endfunction

    function automatic logic [2*IO_W-1:0] predict_frame(logic [2*IO_W-1:0] din);
        logic [DELAY_W-1:0] dl;
        logic [DELAY_W-1:0] dr;
        logic [DELAY_W:0]   half;
        logic [2*IO_W-1:0]  dout;
        if (!en_r)
            return din;                       // bypass, state untouched
        half = ({1'b0, rdly_r} + 17'd1) >> 1; // ping-pong: right delay halved, up
        dl   = pp_r ? half[DELAY_W-1:0] : ldly_r;
        dr   = (sync_r || pp_r) ? dl : rdly_r;
        dout[IO_W-1:0]      = tap_channel(0, din[IO_W-1:0], dl);
        dout[2*IO_W-1:IO_W] = tap_channel(1, din[2*IO_W-1:IO_W], dr);
        wr_ptr = wr_ptr + 16'd1;
        return dout;
    endfunction

    function automatic logic [CFG_DW-1:0] reg_value(int idx);
        case (idx)
            REG_ENABLE:        return CFG_DW'(en_r);
            REG_LEFT_DELAY:    return CFG_DW'(ldly_r);
            REG_RIGHT_DELAY:   return CFG_DW'(rdly_r);
            REG_FEEDBACK_GAIN: return CFG_DW'(gain_r);
            REG_SIDE_SYNC:     return CFG_DW'(sync_r);
            REG_PING_PONG:     return CFG_DW'(pp_r);
            default:           return '0;
        endcase
    endfunction

    function automatic void reg_update(int idx, logic [CFG_DW-1:0] v);
        case (idx)
            REG_ENABLE:        en_r   = v[0];
            REG_LEFT_DELAY:    ldly_r = v[DELAY_W-1:0];
            REG_RIGHT_DELAY:   rdly_r = v[DELAY_W-1:0];
            REG_FEEDBACK_GAIN: gain_r = v[GAIN_W-1:0];
            REG_SIDE_SYNC:     sync_r = v[0];
            REG_PING_PONG:     pp_r   = v[0];
            default: ;                          // outside the map: ignored
        endcase
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < MEM_DEPTH; i++) begin
            echo_mem[0][i] = '0;
            echo_mem[1][i] = '0;
        end
        wr_ptr = '0;
        en_r   = 1'b0;
        ldly_r = DELAY_W'(DELAY_RST);
        rdly_r = DELAY_W'(DELAY_RST);
        gain_r = GAIN_W'(GAIN_RST);
        sync_r = 1'b0;
        pp_r   = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every m_ beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [2*IO_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want = pending_frames.pop_front();
                if (m_tdata[IO_W-1:0] !== want[IO_W-1:0]) begin
                    errors++;
                    $display("%0t: left_out mismatch, expected %h, actual %h",
                             $time, want[IO_W-1:0], m_tdata[IO_W-1:0]);
                end
                if (m_tdata[2*IO_W-1:IO_W] !== want[2*IO_W-1:IO_W]) begin
                    errors++;
                    $display("%0t: right_out mismatch, expected %h, actual %h",
                             $time, want[2*IO_W-1:IO_W], m_tdata[2*IO_W-1:IO_W]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                    default:    m_tready <= ((rx_tick % 7) < 4);
                endcase
            end
            rx_tick++;
        end
    end

    // ------------------------------------------------------------------------
    // APB access (setup + access), register read checked against the model
    // ------------------------------------------------------------------------
    task automatic reg_read_check(int idx);
        logic [CFG_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_AW'(idx * 4);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (got !== reg_value(idx)) begin
            errors++;
            $display("%0t: register %0d readback, expected %h, actual %h",
                     $time, idx, reg_value(idx), got);
        end
    endtask

    task automatic reg_write(int idx, logic [CFG_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(idx * 4);
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        reg_update(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (idx <= int'(REG_PING_PONG))
            reg_read_check(idx);
    endtask

    // write with junk above the field width; only the low bits may stick
    task automatic reg_write_dirty(int idx, int width, logic [CFG_DW-1:0] v);
        reg_write(idx, ($urandom() << width) | v);
    endtask

    // ------------------------------------------------------------------------
    // Sender: one beat, then maybe a gap between bursts
    // ------------------------------------------------------------------------
    task automatic send_frame(logic [2*IO_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        pending_frames.push_back(predict_frame(d));
        if (tx_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    // sender stops and waits for every predicted beat, then a few idle cycles
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [IO_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return IO_W'($urandom());
        endcase
    endfunction

    function automatic logic [DELAY_W-1:0] rand_delay();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return 16'd65535;
            2:       return 16'd1;
            3:       return DELAY_W'($urandom_range(2, 65534));
            default: return DELAY_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 15'h7FFF;
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    task automatic set_run(logic en, logic [DELAY_W-1:0] ld, logic [DELAY_W-1:0] rd,
                           logic [GAIN_W-1:0] g, logic ss, logic pp);
        reg_write(REG_ENABLE, CFG_DW'(en));
        reg_write(REG_LEFT_DELAY, CFG_DW'(ld));
        reg_write(REG_RIGHT_DELAY, CFG_DW'(rd));
        reg_write(REG_FEEDBACK_GAIN, CFG_DW'(g));
        reg_write(REG_SIDE_SYNC, CFG_DW'(ss));
        reg_write(REG_PING_PONG, CFG_DW'(pp));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset values of the register file, then bypass with extreme samples
    task automatic test_reset_bypass();
        for (int i = 0; i <= int'(REG_PING_PONG); i++)
            reg_read_check(i);
        send_frame({16'h8000, 16'h7FFF});
        send_frame({16'h7FFF, 16'h8000});
        send_frame({16'hFFFF, 16'h0000});
        drain_results();
    endtask

    // impulse echoes, recirculation saturation, zero and full gain
    task automatic test_echo_basics();
        set_run(1'b1, 16'd2, 16'd3, 15'd16384, 1'b0, 1'b0);
        send_frame({16'h7FFF, 16'h7FFF});
        repeat (4) send_frame('0);
        drain_results();
        set_run(1'b1, 16'd1, 16'd1, 15'h7FFF, 1'b0, 1'b0);
        repeat (3) send_frame({16'h8000, 16'h7FFF});
        drain_results();
        reg_write(REG_FEEDBACK_GAIN, '0);
        send_frame({16'h7FFF, 16'h8000});
        drain_results();
    endtask

    // zero delay, side-sync, ping-pong (odd and top delay), bypass mid-run,
    // dirty upper bits, and a write past the register map
    task automatic test_mode_cases();
        set_run(1'b1, 16'd0, 16'd0, 15'd20000, 1'b0, 1'b0);
        send_frame({16'h1234, 16'h8000});
        drain_results();
        set_run(1'b1, 16'd1, 16'd4, 15'd30000, 1'b1, 1'b0);
        repeat (2) send_frame({rand_sample(), rand_sample()});
        drain_results();
        reg_write_dirty(REG_RIGHT_DELAY, DELAY_W, 32'd5);
        reg_write_dirty(REG_PING_PONG, 1, 32'd1);
        repeat (3) send_frame({rand_sample(), rand_sample()});
        drain_results();
        reg_write(REG_RIGHT_DELAY, 32'd65535);
        send_frame({16'h7FFF, 16'h7FFF});
        drain_results();
        reg_write_dirty(REG_ENABLE, 1, 32'd0);
        send_frame({16'h5A5A, 16'hA5A5});
        drain_results();
        reg_write(REG_ENABLE, 32'd1);
        send_frame({16'h0001, 16'hFFFE});
        drain_results();
        reg_write(UNUSED_REG, 32'hFFFF_FFFF);
        for (int i = 0; i <= int'(REG_PING_PONG); i++)
            reg_read_check(i);
    endtask

    // receiver holds off while the sender keeps offering beats, so the
    // pipeline fills up and s_tready has to drop
    task automatic test_backpressure();
        set_run(1'b1, 16'd3, 16'd7, 15'd24000, 1'b0, 1'b0);
        tx_gaps  = 1'b0;
        rx_mode  = RX_ALWAYS;
        hold_req = 1'b1;
        repeat (40) send_frame({rand_sample(), rand_sample()});
        drain_results();
    endtask

    // random settings per phase, random traffic and pacing
    task automatic test_random_phases();
        logic en;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            en = ($urandom_range(0, 7) != 0);
            reg_write_dirty(REG_ENABLE, 1, CFG_DW'(en));
            reg_write_dirty(REG_LEFT_DELAY, DELAY_W, CFG_DW'(rand_delay()));
            reg_write_dirty(REG_RIGHT_DELAY, DELAY_W, CFG_DW'(rand_delay()));
            reg_write_dirty(REG_FEEDBACK_GAIN, GAIN_W, CFG_DW'(rand_gain()));
            reg_write_dirty(REG_SIDE_SYNC, 1, CFG_DW'($urandom_range(0, 1)));
            reg_write_dirty(REG_PING_PONG, 1, CFG_DW'($urandom_range(0, 3) == 0));
            rx_mode    = rx_mode_e'(ph % 3);
            tx_gaps    = (ph % 4 != 0);       // every fourth phase runs flat out
            burst_left = $urandom_range(1, 20);
            repeat (PHASE_FRAMES) send_frame({rand_sample(), rand_sample()});
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        model_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_bypass();
        test_echo_basics();
        test_mode_cases();
        test_backpressure();
        test_random_phases();

        drain_results();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
